/* hw/rtl/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the cascaded tick timekeeper.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int CNT_W = 16;
  localparam int MIT_W = 7;
  localparam int TIS_W = 4;
  localparam int SIM_W = 6;
  localparam int DEB_W = 8;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd100;

  // request codes
  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_OVERFLOW = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CNT_W-1:0] engine_speed;
    logic             clear_force_read;
    logic             debounce_load_valid;
    logic [DEB_W-1:0] debounce_load_value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] tick_count;
    logic [CNT_W-1:0] ms_count;
    logic [MIT_W-1:0] ms_in_tenth;
    logic [CNT_W-1:0] tenth_count;
    logic [TIS_W-1:0] tenths_in_second;
    logic [CNT_W-1:0] second_count;
    logic [SIM_W-1:0] seconds_in_minute;
    logic [CNT_W-1:0] minute_count;
    logic [CNT_W-1:0] timeout_count;
    logic             force_flag;
    logic             prime_flag;
    logic             pump_level;
    logic [DEB_W-1:0] debounce_count;
    logic [CNT_W-1:0] overflow_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    tick_count:        '0,
    ms_count:          '0,
    ms_in_tenth:       '0,
    tenth_count:       '0,
    tenths_in_second:  '0,
    second_count:      '0,
    seconds_in_minute: '0,
    minute_count:      '0,
    timeout_count:     '0,
    force_flag:        1'b0,
    prime_flag:        1'b1,
    pump_level:        1'b1,
    debounce_count:    '0,
    overflow_count:    '0
  };

endpackage

/* hw/rtl/ctt_next.sv */
// ----------------------------------------------------------------------------
// ctt_next
// Next-state logic: applies one word to the counter cascade and the
// millisecond, tenth and second tasks.
// ----------------------------------------------------------------------------
module ctt_next #(
  parameter int TICKS_PER_MS       = 8,
  parameter int MS_PER_TENTH       = 100,
  parameter int TENTHS_PER_SECOND  = 10,
  parameter int SECONDS_PER_MINUTE = 60,
  parameter int PRIME_SECONDS      = 4,
  parameter int PHASE_W            = 3
) (
  input  ctt_pkg::state_t          cur,
  input  logic [PHASE_W-1:0]       phase,
  input  ctt_pkg::item_t           item,
  input  logic [15:0]              reading_timeout,
  output ctt_pkg::state_t          nxt,
  output logic [PHASE_W-1:0]       phase_next
);
  import ctt_pkg::*;

  logic             running;
  logic             milli;
  logic             tenth;
  logic             second;
  logic [PHASE_W:0] phase_inc;
  logic [CNT_W-1:0] to_inc;
  logic [MIT_W-1:0] mit_inc;
  logic [TIS_W-1:0] tis_inc;
  logic [SIM_W-1:0] sim_inc;

  always_comb begin
    nxt        = cur;
    phase_next = phase;
    running    = |item.engine_speed;
    milli      = 1'b0;
    tenth      = 1'b0;
    second     = 1'b0;
    phase_inc  = '0;
    to_inc     = '0;
    mit_inc    = '0;
    tis_inc    = '0;
    sim_inc    = '0;

    if (item.clear_force_read) begin
      nxt.force_flag = 1'b0;
    end
    if (item.debounce_load_valid) begin
      nxt.debounce_count = item.debounce_load_value;
    end

    if (item.req_type == REQ_OVERFLOW) begin
      nxt.overflow_count = cur.overflow_count + 16'd1;
    end else begin
      nxt.tick_count = cur.tick_count + 16'd1;
      phase_inc = {1'b0, phase} + {{PHASE_W{1'b0}}, 1'b1};
      // tick count wrap lands on a multiple as well
      if (cur.tick_count == 16'hFFFF ||
          phase_inc == (PHASE_W+1)'(TICKS_PER_MS)) begin
        phase_next = '0;
      end else begin
        phase_next = phase_inc[PHASE_W-1:0];
      end
      milli = (phase_next == '0);
    end

    if (milli) begin
      nxt.ms_count    = cur.ms_count + 16'd1;
      mit_inc         = cur.ms_in_tenth + 7'd1;
      nxt.ms_in_tenth = mit_inc;
      to_inc          = cur.timeout_count + 16'd1;
      if (to_inc > reading_timeout) begin
        nxt.force_flag    = 1'b1;
        nxt.timeout_count = '0;
      end else begin
        nxt.timeout_count = to_inc;
        if (running) begin
          nxt.pump_level = 1'b1;
        end
      end
      tenth = (mit_inc >= MIT_W'(MS_PER_TENTH));
    end

    if (tenth) begin
      nxt.tenth_count = cur.tenth_count + 16'd1;
      nxt.ms_in_tenth = '0;
      tis_inc         = cur.tenths_in_second + 4'd1;
      if (nxt.debounce_count != '0) begin
        nxt.debounce_count = nxt.debounce_count - 8'd1;
      end
      if (tis_inc >= TIS_W'(TENTHS_PER_SECOND)) begin
        nxt.tenths_in_second = '0;
        second               = 1'b1;
      end else begin
        nxt.tenths_in_second = tis_inc;
      end
    end

    if (second) begin
      nxt.second_count = cur.second_count + 16'd1;
      sim_inc          = cur.seconds_in_minute + 6'd1;
      if (cur.prime_flag) begin
        if (sim_inc == SIM_W'(PRIME_SECONDS)) begin
          nxt.prime_flag = 1'b0;
          nxt.pump_level = 1'b0;
        end
      end else if (!running) begin
        nxt.pump_level = 1'b0;
      end
      if (sim_inc >= SIM_W'(SECONDS_PER_MINUTE)) begin
        nxt.minute_count      = cur.minute_count + 16'd1;
        nxt.seconds_in_minute = '0;
      end else begin
        nxt.seconds_in_minute = sim_inc;
      end
    end
  end

endmodule

/* hw/rtl/cascaded_tick_timekeeper.sv */
// ----------------------------------------------------------------------------
// cascaded_tick_timekeeper
// Tick and timer-overflow driven time base with periodic pump, timeout and
// debounce tasks.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, one word per tick or timer overflow
//   output channel: out_valid / out_stall, one result word per input word,
//   carrying the counts and flags after that word is applied
//   config: cfg_wr_en / cfg_wr_data write the reading timeout limit; the user
//   writes it only while no word is in flight, the block does not enforce it
//   pipeline: an accepted word goes from the input register to the result register
//   throughput: one word per cycle while the output is not stalled; the input
//   register feeds the next-state logic and the result register, and state
//   advances when a word moves into the result register
//   reset: counters clear, priming and pump come up on, timeout limit is 100,
//   both pipeline stages empty
//   stall: a stalled result holds; the input register still takes one more
//   word, then in_stall rises until the result is taken
// ----------------------------------------------------------------------------
module cascaded_tick_timekeeper #(
  parameter int TICKS_PER_MS       = 8,
  parameter int MS_PER_TENTH       = 100,
  parameter int TENTHS_PER_SECOND  = 10,
  parameter int SECONDS_PER_MINUTE = 60,
  parameter int PRIME_SECONDS      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] engine_speed,
  input  logic        clear_force_read,
  input  logic        debounce_load_valid,
  input  logic [7:0]  debounce_load_value,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] millis_count,
  output logic [15:0] tenths_count,
  output logic [15:0] seconds_count,
  output logic [15:0] minutes_count,
  output logic        force_read,
  output logic        pump_on,
  output logic        priming,
  output logic        debounce_busy,
  output logic [15:0] timer_extension
);
  import ctt_pkg::*;

  localparam int PHASE_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

  logic               s1_valid;
  item_t              s1_item;
  logic               s1_advance;
  state_t             state;
  state_t             state_next;
  logic [PHASE_W-1:0] tick_phase;
  logic [PHASE_W-1:0] tick_phase_next;
  logic [CNT_W-1:0]   reading_timeout;

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;

  ctt_next #(
    .TICKS_PER_MS       (TICKS_PER_MS),
    .MS_PER_TENTH       (MS_PER_TENTH),
    .TENTHS_PER_SECOND  (TENTHS_PER_SECOND),
    .SECONDS_PER_MINUTE (SECONDS_PER_MINUTE),
    .PRIME_SECONDS      (PRIME_SECONDS),
    .PHASE_W            (PHASE_W)
  ) u_next (
    .cur             (state),
    .phase           (tick_phase),
    .item            (s1_item),
    .reading_timeout (reading_timeout),
    .nxt             (state_next),
    .phase_next      (tick_phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      state           <= STATE_RESET;
      tick_phase      <= '0;
      reading_timeout <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        reading_timeout <= cfg_wr_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && s1_advance) begin
        state      <= state_next;
        tick_phase <= tick_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.req_type            <= req_type;
      s1_item.engine_speed        <= engine_speed;
      s1_item.clear_force_read    <= clear_force_read;
      s1_item.debounce_load_valid <= debounce_load_valid;
      s1_item.debounce_load_value <= debounce_load_value;
    end
    if (s1_valid && s1_advance) begin
      millis_count    <= state_next.ms_count;
      tenths_count    <= state_next.tenth_count;
      seconds_count   <= state_next.second_count;
      minutes_count   <= state_next.minute_count;
      force_read      <= state_next.force_flag;
      pump_on         <= state_next.pump_level;
      priming         <= state_next.prime_flag;
      debounce_busy   <= |state_next.debounce_count;
      timer_extension <= state_next.overflow_count;
    end
  end

endmodule

/* hw/rtl/ctt_checker.sv */
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level checks for the cascaded tick timekeeper, bound to the top level.
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] millis_count,
  input logic        priming
);

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(millis_count))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // priming never comes back once ended
  a_prime_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && !priming |=> !out_valid || !priming)
    else $error("priming restarted");

endmodule

bind cascaded_tick_timekeeper ctt_checker u_ctt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .millis_count (millis_count),
  .priming      (priming)
);

/* sim/cascaded_tick_timekeeper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_tick_timekeeper_test
// Checks the tick timekeeper against a cycle-free predictor of its counter
// cascade, reading timeout, pump, priming and debounce logic. A short table
// of directed words comes first, then random words over several timeout
// limits, with random bursts, gaps, stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module cascaded_tick_timekeeper_test;
  import ctt_pkg::*;

  localparam int TICKS_PER_MS       = 8;
  localparam int MS_PER_TENTH       = 100;
  localparam int TENTHS_PER_SECOND  = 10;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int PRIME_SECONDS      = 4;

  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 242;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 200000;
  localparam int DIR_ROWS    = 19;

  typedef struct packed {
    logic [15:0] ms;
    logic [15:0] tenths;
    logic [15:0] secs;
    logic [15:0] mins;
    logic        force_rd;
    logic        pump;
    logic        prime;
    logic        busy;
    logic [15:0] ext;
  } time_report_t;

  typedef struct packed {
    item_t        w;
    logic         known;
    time_report_t want;
  } dir_row_t;

  localparam time_report_t NONE = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] engine_speed;
  logic        clear_force_read;
  logic        debounce_load_valid;
  logic [7:0]  debounce_load_value;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] millis_count;
  logic [15:0] tenths_count;
  logic [15:0] seconds_count;
  logic [15:0] minutes_count;
  logic        force_read;
  logic        pump_on;
  logic        priming;
  logic        debounce_busy;
  logic [15:0] timer_extension;

  cascaded_tick_timekeeper dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .engine_speed        (engine_speed),
    .clear_force_read    (clear_force_read),
    .debounce_load_valid (debounce_load_valid),
    .debounce_load_value (debounce_load_value),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .millis_count        (millis_count),
    .tenths_count        (tenths_count),
    .seconds_count       (seconds_count),
    .minutes_count       (minutes_count),
    .force_read          (force_read),
    .pump_on             (pump_on),
    .priming             (priming),
    .debounce_busy       (debounce_busy),
    .timer_extension     (timer_extension)
  );

  always #5 clk = ~clk;

  // predicted timekeeper state
  logic [15:0] tick_ctr, ms_ctr, tenth_ctr, sec_ctr, min_ctr, tmo_ctr, ovf_ctr;
  logic [15:0] tmo_limit;
  logic [6:0]  ms_sub;
  logic [3:0]  tenth_sub;
  logic [5:0]  sec_sub;
  logic        force_q, prime_q, pump_q;
  logic [7:0]  deb_ctr;

  time_report_t pending_reports [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  logic         want_hold;
  bit           hold_taken = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{REQ_OVERFLOW, 16'h0000, 1'b0, 1'b0, 8'h00}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1}},
    '{'{REQ_TICK,     16'hFFFF, 1'b1, 1'b1, 8'hFF}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1}},
    '{'{REQ_OVERFLOW, 16'hFFFF, 1'b0, 1'b1, 8'h00}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd2}},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b1, 8'h01}, 1'b1,
      '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1, 16'd2}},
    '{'{REQ_TICK,     16'h8000, 1'b0, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0001, 1'b0, 1'b1, 8'h80}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b0, 8'h7F}, 1'b0, NONE},
    '{'{REQ_TICK,     16'hFFFF, 1'b1, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b0, 8'hFF}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0001, 1'b0, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_OVERFLOW, 16'h0000, 1'b1, 1'b1, 8'h55}, 1'b0, NONE},
    '{'{REQ_TICK,     16'hAAAA, 1'b0, 1'b1, 8'hAA}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h5555, 1'b1, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b1, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_OVERFLOW, 16'hFFFF, 1'b1, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b1, 8'h00}, 1'b0, NONE},
    '{'{REQ_TICK,     16'h0000, 1'b0, 1'b0, 8'h00}, 1'b0, NONE}
  };

  task automatic clear_clock_state();
    tick_ctr  = '0; ms_ctr  = '0; tenth_ctr = '0; sec_ctr = '0; min_ctr = '0;
    tmo_ctr   = '0; ovf_ctr = '0; ms_sub    = '0; tenth_sub = '0; sec_sub = '0;
    force_q   = 1'b0; prime_q = 1'b1; pump_q = 1'b1; deb_ctr = '0;
    tmo_limit = TIMEOUT_RESET;
  endtask

  function automatic time_report_t advance_timekeeper(input item_t w);
    time_report_t r;
    logic         running;
    running = (w.engine_speed != 16'd0);
    if (w.clear_force_read) force_q = 1'b0;
    if (w.debounce_load_valid) deb_ctr = w.debounce_load_value;
    if (w.req_type == REQ_OVERFLOW) begin
      ovf_ctr = ovf_ctr + 16'd1;
    end else begin
      tick_ctr = tick_ctr + 16'd1;
      if (tick_ctr % TICKS_PER_MS == 0) begin
        ms_ctr  = ms_ctr + 16'd1;
        ms_sub  = ms_sub + 7'd1;
        tmo_ctr = tmo_ctr + 16'd1;
        if (tmo_ctr > tmo_limit) begin
          force_q = 1'b1;
          tmo_ctr = '0;
        end else if (running) begin
          pump_q = 1'b1;
        end
        if (ms_sub >= MS_PER_TENTH) begin
          tenth_ctr = tenth_ctr + 16'd1;
          tenth_sub = tenth_sub + 4'd1;
          ms_sub    = '0;
          if (deb_ctr != 8'd0) deb_ctr = deb_ctr - 8'd1;
          if (tenth_sub >= TENTHS_PER_SECOND) begin
            tenth_sub = '0;
            sec_ctr   = sec_ctr + 16'd1;
            sec_sub   = sec_sub + 6'd1;
            if (prime_q) begin
              if (sec_sub == PRIME_SECONDS) begin
                prime_q = 1'b0;
                pump_q  = 1'b0;
              end
            end else if (!running) begin
              pump_q = 1'b0;
            end
            if (sec_sub >= SECONDS_PER_MINUTE) begin
              min_ctr = min_ctr + 16'd1;
              sec_sub = '0;
            end
          end
        end
      end
    end
    r = '{ms_ctr, tenth_ctr, sec_ctr, min_ctr, force_q, pump_q, prime_q,
          deb_ctr != 8'd0, ovf_ctr};
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < 30)
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // called right after a rising edge
  task automatic send_word(input item_t w, input logic known, input time_report_t typed);
    time_report_t p;
    in_valid            <= 1'b1;
    req_type            <= w.req_type;
    engine_speed        <= w.engine_speed;
    clear_force_read    <= w.clear_force_read;
    debounce_load_valid <= w.debounce_load_valid;
    debounce_load_value <= w.debounce_load_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = advance_timekeeper(w);
    pending_reports.push_back(known ? typed : p);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tmo_limit = v;
  endtask

  // result checking
  always @(posedge clk) begin
    time_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected word", millis_count, 0);
      end else begin
        want = pending_reports.pop_front();
        if (millis_count !== want.ms) flag_mismatch("millis_count", millis_count, want.ms);
        if (tenths_count !== want.tenths)
          flag_mismatch("tenths_count", tenths_count, want.tenths);
        if (seconds_count !== want.secs)
          flag_mismatch("seconds_count", seconds_count, want.secs);
        if (minutes_count !== want.mins)
          flag_mismatch("minutes_count", minutes_count, want.mins);
        if (force_read !== want.force_rd) flag_mismatch("force_read", force_read, want.force_rd);
        if (pump_on !== want.pump) flag_mismatch("pump_on", pump_on, want.pump);
        if (priming !== want.prime) flag_mismatch("priming", priming, want.prime);
        if (debounce_busy !== want.busy) flag_mismatch("debounce_busy", debounce_busy, want.busy);
        if (timer_extension !== want.ext)
          flag_mismatch("timer_extension", timer_extension, want.ext);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall patterns, plus one long hold-off
  initial begin
    int mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      if (want_hold === 1'b1 && !hold_taken) begin
        hold_taken = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 4);
      span = $urandom_range(8, 48);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          3: out_stall <= ($urandom_range(0, 6) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // stimulus
  initial begin
    item_t       w;
    int          burst_left;
    int          gap;
    int          spins;
    logic [15:0] limit_val;
    rst                 <= 1'b1;
    in_valid            <= 1'b0;
    req_type            <= REQ_TICK;
    engine_speed        <= '0;
    clear_force_read    <= 1'b0;
    debounce_load_valid <= 1'b0;
    debounce_load_value <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    want_hold           <= 1'b0;
    clear_clock_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].known, dir_tab[i].want);
    drain_words();

    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: limit_val = 16'd0;
        1: limit_val = 16'hFFFF;
        2: limit_val = 16'd1;
        3: limit_val = 16'($urandom_range(2, 30));
        4: limit_val = TIMEOUT_RESET;
        5: limit_val = 16'hFFFE;
        6: limit_val = 16'($urandom);
        default: limit_val = 16'd0;
      endcase
      write_timeout(limit_val);
      if (ph == 2) want_hold <= 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = (ph == 5 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        w.req_type = ($urandom_range(0, 99) < 85) ? REQ_TICK : REQ_OVERFLOW;
        case ($urandom_range(0, 5))
          0, 1:    w.engine_speed = 16'd0;
          2:       w.engine_speed = 16'hFFFF;
          default: w.engine_speed = 16'($urandom);
        endcase
        w.clear_force_read    = ($urandom_range(0, 7) == 0);
        w.debounce_load_valid = ($urandom_range(0, 19) == 0);
        w.debounce_load_value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3))
                                                            : 8'($urandom);
        send_word(w, 1'b0, NONE);
      end
      drain_words();
    end

    spins = 0;
    while (pending_reports.size() != 0 && spins < 1000) begin
      @(posedge clk);
      spins++;
    end
    if (pending_reports.size() != 0)
      flag_mismatch("words never returned", pending_reports.size(), 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
